### sv/ring_record_offset_lookup_assert.svh
// assertion macros for the ring record offset lookup checker
`ifndef RING_RECORD_OFFSET_LOOKUP_ASSERT_SVH
`define RING_RECORD_OFFSET_LOOKUP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RROL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrol check failed");

// next-cycle implication, sampled on clk, off while in reset
`define RROL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrol check failed");

`endif

### sv/rrol_pkg.sv
package rrol_pkg;

  localparam int SLOTS       = 16;
  localparam int LENGTH_BITS = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REC_LEN_W   = 16;
  localparam int POS_W       = 20;
  localparam int OUT_SLOT_W  = 4;
  localparam int OUT_OFF_W   = 16;
  // running sum over all slots never wraps at this width
  localparam int SUM_W       = LENGTH_BITS + SLOT_W + 1;
  localparam int CMP_W       = ((SUM_W > POS_W) ? SUM_W : POS_W) + 1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_FIND = 1'b1
  } cmd_t;

  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_status_t;

  function automatic slot_idx_t next_slot(slot_idx_t s);
    if (s == SLOT_W'(SLOTS - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = s + 1'b1;
    end
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] to_out_slot(slot_idx_t s);
    logic [SLOT_W+OUT_SLOT_W-1:0] t;
    t = {{OUT_SLOT_W{1'b0}}, s};
    to_out_slot = t[OUT_SLOT_W-1:0];
  endfunction

  function automatic len_t to_len(logic [REC_LEN_W-1:0] r);
    logic [LENGTH_BITS+REC_LEN_W-1:0] t;
    t = {{LENGTH_BITS{1'b0}}, r};
    to_len = t[LENGTH_BITS-1:0];
  endfunction

endpackage

### sv/rrol_in_if.sv
interface rrol_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [rrol_pkg::REC_LEN_W-1:0] record_length;
  logic [rrol_pkg::POS_W-1:0]     char_position;

  modport source (
    output valid, command, record_length, char_position,
    input  ready
  );
  modport sink (
    input  valid, command, record_length, char_position,
    output ready
  );
endinterface

### sv/rrol_out_if.sv
interface rrol_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [rrol_pkg::OUT_SLOT_W-1:0] slot;
  logic [rrol_pkg::OUT_OFF_W-1:0]  offset_in_record;

  modport source (
    output valid, hit, slot, offset_in_record,
    input  ready
  );
  modport sink (
    input  valid, hit, slot, offset_in_record,
    output ready
  );
endinterface

### sv/rrol_ram.sv
module rrol_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/rrol_ctrl.sv
module rrol_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_is_find,
  input  rrol_pkg::dp_status_t   status,
  output logic                   in_ready,
  output rrol_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ready_nxt = ready_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid & ready_r;
        if (in_valid && ready_r) begin
          ready_nxt = 1'b0;
          state_nxt = in_is_find ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
          ready_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_ready = ready_r;

endmodule

### sv/rrol_datapath.sv
module rrol_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rrol_pkg::ctrl_cmd_t               cmd,
  output rrol_pkg::dp_status_t              status,
  input  logic                              in_command,
  input  logic [rrol_pkg::REC_LEN_W-1:0]    in_record_length,
  input  logic [rrol_pkg::POS_W-1:0]        in_char_position,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [rrol_pkg::OUT_SLOT_W-1:0]   out_slot,
  output logic [rrol_pkg::OUT_OFF_W-1:0]    out_offset_in_record
);

  // ring pointers and written marks
  rrol_pkg::slot_idx_t           newest_r, oldest_r;
  logic                          empty_r, full_r;
  logic [rrol_pkg::SLOTS-1:0]    written_r;

  // walk state
  logic [rrol_pkg::POS_W-1:0]    pos_r;
  logic [rrol_pkg::SUM_W-1:0]    sum_r;
  rrol_pkg::slot_idx_t           walk_r;
  rrol_pkg::slot_idx_t           cnt_r;

  // finished result, then output register
  logic                          res_hit_r;
  logic [rrol_pkg::OUT_SLOT_W-1:0] res_slot_r;
  logic [rrol_pkg::OUT_OFF_W-1:0]  res_off_r;
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [rrol_pkg::OUT_SLOT_W-1:0] out_slot_r;
  logic [rrol_pkg::OUT_OFF_W-1:0]  out_off_r;

  logic                          add_acc, find_acc;
  rrol_pkg::slot_idx_t           add_idx;
  logic                          add_full;
  rrol_pkg::slot_idx_t           rd_addr;
  rrol_pkg::len_t                rd_data;
  logic [rrol_pkg::CMP_W-1:0]    pos_ext, sum_ext, end_ext, diff;
  logic                          slot_ok, in_rec, last_step;

  assign add_acc  = cmd.accept && (in_command == rrol_pkg::CMD_ADD);
  assign find_acc = cmd.accept && (in_command == rrol_pkg::CMD_FIND);

  // first add after reset reuses slot zero, later adds advance
  assign add_idx  = empty_r ? newest_r : rrol_pkg::next_slot(newest_r);
  assign add_full = full_r | (!empty_r && (add_idx == '0));

  assign rd_addr  = find_acc ? oldest_r : rrol_pkg::next_slot(walk_r);

  rrol_ram #(
    .WIDTH (rrol_pkg::LENGTH_BITS),
    .DEPTH (rrol_pkg::SLOTS)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (add_acc),
    .wr_addr (add_idx),
    .wr_data (rrol_pkg::to_len(in_record_length)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // one slot per cycle: rd_data holds the length of walk_r
  assign pos_ext   = rrol_pkg::CMP_W'(pos_r);
  assign sum_ext   = rrol_pkg::CMP_W'(sum_r);
  assign end_ext   = sum_ext + rrol_pkg::CMP_W'(rd_data);
  assign diff      = pos_ext - sum_ext;
  assign slot_ok   = written_r[walk_r];
  assign in_rec    = slot_ok && (pos_ext >= sum_ext) && (pos_ext < end_ext);
  assign last_step = (cnt_r == rrol_pkg::SLOT_W'(rrol_pkg::SLOTS - 1));

  assign status.walk_done = !slot_ok || in_rec || last_step;
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r    <= '0;
      oldest_r    <= '0;
      empty_r     <= 1'b1;
      full_r      <= 1'b0;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (add_acc) begin
        newest_r           <= add_idx;
        empty_r            <= 1'b0;
        full_r             <= add_full;
        written_r[add_idx] <= 1'b1;
        if (!empty_r && add_full) begin
          oldest_r <= rrol_pkg::next_slot(oldest_r);
        end
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_acc) begin
      res_hit_r  <= 1'b1;
      res_slot_r <= rrol_pkg::to_out_slot(add_idx);
      res_off_r  <= '0;
    end
    if (find_acc) begin
      pos_r  <= in_char_position;
      sum_r  <= '0;
      walk_r <= oldest_r;
      cnt_r  <= '0;
    end
    if (cmd.walk) begin
      if (in_rec) begin
        res_hit_r  <= 1'b1;
        res_slot_r <= rrol_pkg::to_out_slot(walk_r);
        res_off_r  <= diff[rrol_pkg::OUT_OFF_W-1:0];
      end else if (!slot_ok || last_step) begin
        res_hit_r  <= 1'b0;
        res_slot_r <= '0;
        res_off_r  <= '0;
      end else begin
        sum_r  <= end_ext[rrol_pkg::SUM_W-1:0];
        walk_r <= rrol_pkg::next_slot(walk_r);
        cnt_r  <= cnt_r + 1'b1;
      end
    end
    if (cmd.publish) begin
      out_hit_r  <= res_hit_r;
      out_slot_r <= res_slot_r;
      out_off_r  <= res_off_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_slot             = out_slot_r;
  assign out_offset_in_record = out_off_r;

endmodule

### sv/ring_record_offset_lookup.sv
// channel  dir  fields                                    handshake
// in_if    in   command, record_length, char_position     valid/ready
// out_if   out  hit, slot, offset_in_record               valid/ready
//
// add: result is registered as the word is taken, with no walk
// find: walks 1 to SLOTS slots, paced by the single
//   read port of the length ram, which delivers one stored length a cycle
// one command in flight; in_if.ready returns once the result is in the output register
// reset clears pointers and written marks at once, no clearing pass
// a stalled result waits in the output register; the walk itself never stalls
module ring_record_offset_lookup (
  input  logic              clk,
  input  logic              rst_n,
  rrol_in_if.sink           in_if,
  rrol_out_if.source        out_if
);

  // command and status between the sequencer and the datapath
  rrol_pkg::ctrl_cmd_t  cmd;
  rrol_pkg::dp_status_t status;
  logic                 in_is_find;

  // command decode, add is a single write, find walks from the oldest slot
  assign in_is_find = (in_if.command == rrol_pkg::CMD_FIND);

  // sequencer: idle, walk, hand over result
  rrol_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_is_find (in_is_find),
    .status     (status),
    .in_ready   (in_if.ready),
    .cmd        (cmd)
  );

  // ring pointers, length ram, running sum and output register
  rrol_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_command           (in_if.command),
    .in_record_length     (in_if.record_length),
    .in_char_position     (in_if.char_position),
    .out_ready            (out_if.ready),
    .out_valid            (out_if.valid),
    .out_hit              (out_if.hit),
    .out_slot             (out_if.slot),
    .out_offset_in_record (out_if.offset_in_record)
  );

endmodule

### sv/rrol_checker.sv
`include "ring_record_offset_lookup_assert.svh"

module rrol_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [rrol_pkg::OUT_SLOT_W-1:0] out_slot,
  input logic [rrol_pkg::OUT_OFF_W-1:0]  out_offset_in_record
);

  // a stalled word holds
  `RROL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_slot) && $stable(out_offset_in_record))
  // a miss carries slot and offset zero
  `RROL_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, (out_slot == '0) && (out_offset_in_record == '0))
  // one command at a time: ready drops after a word is taken
  `RROL_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready)
  // a new result appears only as the block comes back from busy
  `RROL_ASSERT_NOW(a_result_end, $rose(out_valid), in_ready && !$past(in_ready))

endmodule

bind ring_record_offset_lookup rrol_checker u_rrol_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_if.valid),
  .in_ready             (in_if.ready),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_hit              (out_if.hit),
  .out_slot             (out_if.slot),
  .out_offset_in_record (out_if.offset_in_record)
);
